@@ rtl/bdlp_pkg.sv @@
package bdlp_pkg;

  localparam int unsigned MaxButtons     = 4;
  localparam int unsigned NumButtonsDflt = 4;

  localparam int unsigned DbTicksW   = 8;
  localparam int unsigned HoldTicksW = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  // debounce compare only needs to tell "above 255"; saturate at 9 bits
  localparam int unsigned DbCntW   = 9;
  localparam int unsigned HoldCntW = 16;

  localparam logic [DbTicksW-1:0]   DbTicksRst   = 8'd30;
  localparam logic [HoldTicksW-1:0] HoldTicksRst = 16'd750;

  localparam logic [CfgIdxW-1:0] CfgDebounceIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHoldIdx     = 1'b1;

  typedef enum logic [1:0] {
    CodeIdle   = 2'd0,
    CodeActive = 2'd1,
    CodeToggle = 2'd2,
    CodeMode   = 2'd3
  } code_e;

  typedef struct packed {
    code_e code;
    logic  hit;   // change accepted or mode reached this tick
  } btn_status_t;

endpackage

@@ rtl/bdlp_button.sv @@
module bdlp_button (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                pressed_i,
  input  logic [bdlp_pkg::DbTicksW-1:0]       db_ticks_i,
  input  logic [bdlp_pkg::HoldTicksW-1:0]     hold_ticks_i,
  output bdlp_pkg::btn_status_t               status_o
);

  logic                              stable_q, stable_d;
  logic                              armed_q, armed_d;
  logic [bdlp_pkg::DbCntW-1:0]       db_cnt_q, db_cnt_d;
  logic                              hold_q, hold_d;
  logic [bdlp_pkg::HoldCntW-1:0]     hold_cnt_q, hold_cnt_d;
  bdlp_pkg::code_e                   code_q, code_d;

  logic                              armed_now;
  logic [bdlp_pkg::DbCntW-1:0]       db_cnt_now;
  logic [bdlp_pkg::HoldCntW-1:0]     hold_cnt_inc;
  logic                              accept;
  logic                              mode_hit;

  always_comb begin
    db_cnt_now = db_cnt_q;
    if (armed_q && (db_cnt_q != '1)) begin
      db_cnt_now = db_cnt_q + 1'b1;
    end
    hold_cnt_inc = hold_cnt_q;
    if (hold_q && (hold_cnt_q != '1)) begin
      hold_cnt_inc = hold_cnt_q + 1'b1;
    end
    // a press arms an idle timer from zero
    armed_now = armed_q | pressed_i;
    if (pressed_i && !armed_q) begin
      db_cnt_now = '0;
    end
    accept = (pressed_i != stable_q) &&
             (!armed_now || (db_cnt_now > {1'b0, db_ticks_i}));
  end

  always_comb begin
    stable_d   = stable_q;
    armed_d    = armed_now;
    db_cnt_d   = db_cnt_now;
    hold_d     = hold_q;
    hold_cnt_d = hold_cnt_inc;
    code_d     = code_q;
    mode_hit   = 1'b0;
    if (accept) begin
      stable_d = pressed_i;
      armed_d  = 1'b0;
      db_cnt_d = '0;
    end
    if (pressed_i && accept) begin
      hold_d     = 1'b1;
      hold_cnt_d = '0;
      code_d     = bdlp_pkg::CodeActive;
    end else if (pressed_i && hold_q) begin
      if (hold_cnt_inc >= hold_ticks_i) begin
        code_d     = bdlp_pkg::CodeMode;
        hold_d     = 1'b0;
        hold_cnt_d = '0;
        mode_hit   = 1'b1;
      end
    end else if (!pressed_i && accept) begin
      code_d     = bdlp_pkg::CodeToggle;
      hold_d     = 1'b0;
      hold_cnt_d = '0;
    end else begin
      code_d = bdlp_pkg::CodeIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b0;
      armed_q    <= 1'b0;
      db_cnt_q   <= '0;
      hold_q     <= 1'b0;
      hold_cnt_q <= '0;
      code_q     <= bdlp_pkg::CodeIdle;
    end else if (step_i) begin
      stable_q   <= stable_d;
      armed_q    <= armed_d;
      db_cnt_q   <= db_cnt_d;
      hold_q     <= hold_d;
      hold_cnt_q <= hold_cnt_d;
      code_q     <= code_d;
    end
  end

  assign status_o.code = code_d;
  assign status_o.hit  = accept | mode_hit;

endmodule

@@ rtl/button_debounce_long_press.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   pin_levels_i
// out      output     out_valid_o / out_stall_i packed_codes_o, changed_o, any_pressed_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One poll per clock while the output is not stalled; a poll's result passes through the
// input register, then the per-button update into the output register.
// Reset clears all button state and loads the default debounce and hold times.
// While the output is stalled the input register keeps one more poll, then
// in_stall_o is raised.
module button_debounce_long_press #(
  parameter int unsigned NumButtons = bdlp_pkg::NumButtonsDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [3:0]                        pin_levels_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        packed_codes_o,
  output logic                              changed_o,
  output logic                              any_pressed_o,
  input  logic                              cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [bdlp_pkg::DbTicksW-1:0]   db_ticks_q;
  logic [bdlp_pkg::HoldTicksW-1:0] hold_ticks_q;

  logic       s1_valid_q;
  logic [3:0] pins_q;
  logic       out_valid_q;
  logic [7:0] packed_q;
  logic       changed_q;
  logic       any_q;

  logic       in_xfer;
  logic       out_load;
  logic       step;

  logic [7:0] code_w;
  logic [3:0] hit_w;
  logic [3:0] press_w;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_ticks_q   <= bdlp_pkg::DbTicksRst;
      hold_ticks_q <= bdlp_pkg::HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bdlp_pkg::CfgDebounceIdx: db_ticks_q   <= cfg_data_i[bdlp_pkg::DbTicksW-1:0];
        bdlp_pkg::CfgHoldIdx:     hold_ticks_q <= cfg_data_i[bdlp_pkg::HoldTicksW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < bdlp_pkg::MaxButtons; b++) begin : g_btn
    if (b < NumButtons) begin : g_used
      bdlp_pkg::btn_status_t st;

      bdlp_button u_button (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .step_i       (step),
        .pressed_i    (!pins_q[b]),
        .db_ticks_i   (db_ticks_q),
        .hold_ticks_i (hold_ticks_q),
        .status_o     (st)
      );

      assign code_w[2*b +: 2] = st.code;
      assign hit_w[b]         = st.hit;
      assign press_w[b]       = !pins_q[b];
    end else begin : g_unused
      assign code_w[2*b +: 2] = 2'b00;
      assign hit_w[b]         = 1'b0;
      assign press_w[b]       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer || (s1_valid_q && !out_load);
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pins_q <= pin_levels_i;
    end
    if (step) begin
      packed_q  <= code_w;
      changed_q <= |hit_w;
      any_q     <= |press_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_codes_o = packed_q;
  assign changed_o      = changed_q;
  assign any_pressed_o  = any_q;

endmodule
